// File: rtl/core/sidt_pkg.sv
// sidt_pkg: shared constants, result status codes and the digit adjust function
// for the signed integer to decimal text block
// depends on nothing
package sidt_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int CNT_W       = 4;
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);
  localparam int CFG_W       = 8;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_W-1:0] BUFFER_SIZE_RESET = 8'd12;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_ROOM = 2'd1,
    STATUS_TRUNC   = 2'd2
  } status_t;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // add 3 to a bcd digit of 5 or more ahead of the shift
  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

// File: rtl/core/sidt_dabble.sv
// sidt_dabble: bit-serial binary to bcd converter (shift and add 3)
// one magnitude bit enters the bcd shift register per cycle
// depends on sidt_pkg
module sidt_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [sidt_pkg::VALUE_W-1:0]    magnitude,
  output logic                            done,
  output logic [sidt_pkg::BCD_W-1:0]      bcd
);

  logic [sidt_pkg::VALUE_W-1:0]     bin;
  logic [sidt_pkg::SHIFT_CNT_W-1:0] count;
  logic                             running;
  logic [sidt_pkg::BCD_W-1:0]       adjusted;

  always_comb begin
    for (int i = 0; i < sidt_pkg::BCD_DIGITS; i++) begin
      adjusted[4*i +: 4] = sidt_pkg::dabble_adjust(bcd[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == sidt_pkg::SHIFT_CNT_W'(sidt_pkg::VALUE_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= magnitude;
      bcd <= '0;
    end else if (running) begin
      bcd <= {adjusted[sidt_pkg::BCD_W-2:0], bin[sidt_pkg::VALUE_W-1]};
      bin <= {bin[sidt_pkg::VALUE_W-2:0], 1'b0};
    end
  end

endmodule

// File: rtl/core/signed_int_to_decimal_text.sv
// signed_int_to_decimal_text: top level, command port, apb register and text sequencer
// depends on sidt_pkg and sidt_dabble
//
// A word is taken when start is high and busy is low. The value is made positive, turned
// into ten bcd digits by a bit-serial converter (one bit per cycle), leading zero
// digits are dropped one per cycle, and then one word a cycle leaves on the result ports:
// an optional '-', the digits most significant first and a terminator (code 0) with last,
// status and text_length. Each word is shown for exactly one cycle under strobe; the
// receiver cannot stall. buffer_size (apb offset 0, reset 12) is the room for the text
// including its terminator; with too little room for the first digit, or for a negative
// value's sign and first digit, only a status word goes out (char_valid low, status no
// room). The busy time of a value is set by the conversion loop, the digit-serial scan
// and the words it emits; a value without room goes straight to its status word.
module signed_int_to_decimal_text (
  input  logic                                clk,
  input  logic                                rst,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sidt_pkg::VALUE_W-1:0] value,
  // result side
  output logic                                strobe,
  output logic [sidt_pkg::CHAR_W-1:0]         char_code,
  output logic                                char_valid,
  output logic                                last,
  output logic [1:0]                          status,
  output logic [sidt_pkg::CNT_W-1:0]          text_length,
  // apb register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sidt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sidt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sidt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CONV   = 7'b0000010,
    S_SKIP   = 7'b0000100,
    S_PLAN   = 7'b0001000,
    S_SIGN   = 7'b0010000,
    S_DIGITS = 7'b0100000,
    S_TERM   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [sidt_pkg::CFG_W-1:0]   buffer_size;
  logic                         neg;        // value was negative
  logic                         noroom;     // too little room, only a status word goes out
  logic                         trunc;      // digits cut short
  logic [sidt_pkg::BCD_W-1:0]   digits;     // bcd digits, most significant on top
  logic [sidt_pkg::CNT_W-1:0]   ndig;       // significant digits of the magnitude
  logic [sidt_pkg::CNT_W-1:0]   ecnt;       // digits still to emit

  logic                         accept;
  logic                         conv_done;
  logic [sidt_pkg::BCD_W-1:0]   conv_bcd;
  logic [sidt_pkg::VALUE_W-1:0] magnitude;
  logic                         noroom_in;
  logic [sidt_pkg::CFG_W-1:0]   room_left;  // room for digits after the sign
  logic                         trunc_c;
  logic [sidt_pkg::CNT_W-1:0]   ecnt_c;
  logic [3:0]                   top_digit;
  logic                         cfg_write;

  // ---------------------------------------------------------------- apb register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= sidt_pkg::BUFFER_SIZE_RESET;
    end else if (cfg_write && !paddr[2]) begin
      buffer_size <= pwdata[sidt_pkg::CFG_W-1:0];
    end
  end

  // only offset 0 holds a register; the upper word reads as zero
  assign prdata = paddr[2] ? '0
                           : {{(sidt_pkg::APB_DATA_W - sidt_pkg::CFG_W){1'b0}}, buffer_size};

  // ---------------------------------------------------------------- command side
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // two's complement magnitude, the most negative value comes out right as unsigned
  assign magnitude = value[sidt_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

  // a positive value or zero needs one character of room, a negative one two
  assign noroom_in = (buffer_size < 8'd2) ||
                     (value[sidt_pkg::VALUE_W-1] && (buffer_size < 8'd3));

  sidt_dabble u_dabble (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && !noroom_in),
    .magnitude (magnitude),
    .done      (conv_done),
    .bcd       (conv_bcd)
  );

  // ---------------------------------------------------------------- planning
  assign top_digit = digits[sidt_pkg::BCD_W-1 -: 4];
  assign room_left = neg ? (buffer_size - 8'd2) : (buffer_size - 8'd1);
  assign trunc_c   = {{(sidt_pkg::CFG_W - sidt_pkg::CNT_W){1'b0}}, ndig} > room_left;
  // when truncating, room_left is below ndig, so its low bits hold it exactly
  assign ecnt_c    = trunc_c ? (room_left[sidt_pkg::CNT_W-1:0] - 1'b1) : ndig;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = noroom_in ? S_TERM : S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!((top_digit == 4'd0) && (ndig != 4'd1))) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        if (neg) begin
          state_next = S_SIGN;
        end else begin
          state_next = (ecnt_c != '0) ? S_DIGITS : S_TERM;
        end
      end
      S_SIGN: begin
        state_next = (ecnt != '0) ? S_DIGITS : S_TERM;
      end
      S_DIGITS: begin
        if (ecnt == 4'd1) begin
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neg    <= 1'b0;
      noroom <= 1'b0;
      trunc  <= 1'b0;
      ndig   <= '0;
      ecnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            neg    <= value[sidt_pkg::VALUE_W-1];
            noroom <= noroom_in;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            ndig <= sidt_pkg::CNT_W'(sidt_pkg::BCD_DIGITS);
          end
        end
        S_SKIP: begin
          // drop leading zero digits, a zero keeps its single digit
          if ((top_digit == 4'd0) && (ndig != 4'd1)) begin
            ndig <= ndig - 1'b1;
          end
        end
        S_PLAN: begin
          trunc <= trunc_c;
          ecnt  <= ecnt_c;
        end
        S_DIGITS: begin
          ecnt <= ecnt - 1'b1;
        end
        S_SIGN, S_TERM: begin
        end
        default: begin
        end
      endcase
    end
  end

  // bcd digit shift register, one digit leaves the top per cycle while zeros are skipped or digits emitted
  always_ff @(posedge clk) begin
    if ((state == S_CONV) && conv_done) begin
      digits <= conv_bcd;
    end else if (((state == S_SKIP) && (top_digit == 4'd0) && (ndig != 4'd1)) ||
                 (state == S_DIGITS)) begin
      digits <= {digits[sidt_pkg::BCD_W-5:0], 4'd0};
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_SIGN) || (state == S_DIGITS) || (state == S_TERM);
    end
  end

  always_ff @(posedge clk) begin
    priority case (1'b1)
      (state == S_SIGN): begin
        char_code   <= sidt_pkg::CHAR_MINUS;
        char_valid  <= 1'b1;
        last        <= 1'b0;
        status      <= sidt_pkg::STATUS_OK;
        text_length <= '0;
      end
      (state == S_DIGITS): begin
        char_code   <= sidt_pkg::CHAR_ZERO + {4'd0, top_digit};
        char_valid  <= 1'b1;
        last        <= 1'b0;
        status      <= sidt_pkg::STATUS_OK;
        text_length <= '0;
      end
      (state == S_TERM): begin
        char_code   <= sidt_pkg::CHAR_NUL;
        char_valid  <= !noroom;
        last        <= 1'b1;
        if (noroom) begin
          status      <= sidt_pkg::STATUS_NO_ROOM;
          text_length <= '0;
        end else if (trunc) begin
          status      <= sidt_pkg::STATUS_TRUNC;
          text_length <= '0;
        end else begin
          status      <= sidt_pkg::STATUS_OK;
          text_length <= ndig;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/sidt_checker.sv
// sidt_checker: port-level assertions for the decimal text block, bound to the top level
// depends on sidt_pkg
module sidt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe,
  input logic                         char_valid,
  input logic                         last,
  input logic [1:0]                   status,
  input logic [sidt_pkg::CNT_W-1:0]   text_length
);

  // reset leaves the block free to take a word
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  // an accepted word always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // only the final word of a conversion may appear once busy has dropped
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final word while idle");

  // status and length are zero on every word but the last
  a_mid_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> ((status == sidt_pkg::STATUS_OK) && (text_length == '0)))
    else $error("status or length on a non-final word");

  // an empty word only reports lack of room
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && !char_valid) |-> (last && (status == sidt_pkg::STATUS_NO_ROOM)))
    else $error("empty word without no-room status");

endmodule

bind signed_int_to_decimal_text sidt_checker u_sidt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .char_valid  (char_valid),
  .last        (last),
  .status      (status),
  .text_length (text_length)
);

// File: verif/signed_int_to_decimal_text_tb.sv
// signed_int_to_decimal_text_tb: self-checking testbench for the decimal text converter
// drives values on the command port, sets buffer_size over apb and checks every text word
// depends on sidt_pkg and signed_int_to_decimal_text
module signed_int_to_decimal_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register offsets on the apb port
  localparam logic [sidt_pkg::APB_ADDR_W-1:0] ADDR_BUFFER_SIZE = '0;

  localparam int DIGIT_SLOTS    = 12;
  localparam int SETTLE_CYCLES  = 64;    // longest busy stretch of one value plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side

  // one value waiting to be sent, with the idle cycles ahead of it
  typedef struct {
    logic signed [sidt_pkg::VALUE_W-1:0] val;
    int unsigned                         gap;
    bit                                  drain;  // hold off until all earlier text is out
  } pending_value_t;

  // one text word as it should leave the block
  typedef struct packed {
    logic [sidt_pkg::CHAR_W-1:0] code;
    logic                        valid;
    logic                        fin;
    sidt_pkg::status_t           stat;
    logic [sidt_pkg::CNT_W-1:0]  length;
  } text_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                start = 1'b0;
  logic                                busy;
  logic signed [sidt_pkg::VALUE_W-1:0] value = '0;

  logic                                strobe;
  logic [sidt_pkg::CHAR_W-1:0]         char_code;
  logic                                char_valid;
  logic                                last;
  logic [1:0]                          status;
  logic [sidt_pkg::CNT_W-1:0]          text_length;

  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [sidt_pkg::APB_ADDR_W-1:0]     paddr = '0;
  logic [sidt_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [sidt_pkg::APB_DATA_W-1:0]     prdata;
  logic                                pready;

  signed_int_to_decimal_text uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .strobe      (strobe),
    .char_code   (char_code),
    .char_valid  (char_valid),
    .last        (last),
    .status      (status),
    .text_length (text_length),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  // values still to send and text words still to arrive
  pending_value_t values_pending[$];
  text_word_t     text_expected[$];

  // shadow of the block: buffer_size and the digit store
  logic [sidt_pkg::CFG_W-1:0] room_setting = sidt_pkg::BUFFER_SIZE_RESET;
  logic [3:0]                 digit_slots[DIGIT_SLOTS];
  logic [3:0]                 digit_total = '0;
  logic [3:0]                 emitted_digits = '0;

  int words_queued   = 0;
  int words_taken    = 0;   // updated with nonblocking assignment, read by the sequencer
  int words_checked  = 0;
  int no_room_count  = 0;
  int truncated      = 0;
  int settings_used  = 0;
  int fail_count     = 0;

  // work out the text words that one value gives under the current buffer_size
  task automatic predict_text(input logic [sidt_pkg::VALUE_W-1:0] raw);
    logic                         neg;
    logic [sidt_pkg::VALUE_W-1:0] mag;
    int                           room;
    int                           i;
    neg  = raw[sidt_pkg::VALUE_W-1];
    mag  = neg ? (32'd0 - raw) : raw;
    room = int'(room_setting) - 1;

    // no room for the first digit, or for a sign and a digit: a lone status word
    if (room < 1 || (neg && room < 2)) begin
      text_expected.push_back('{sidt_pkg::CHAR_NUL, 1'b0, 1'b1, sidt_pkg::STATUS_NO_ROOM, 4'd0});
      no_room_count++;
      return;
    end

    // zero takes a single digit
    if (mag == 0) begin
      digit_slots[0] = 4'd0;
      digit_total    = 4'd1;
      emitted_digits = 4'd1;
      text_expected.push_back('{sidt_pkg::CHAR_ZERO, 1'b1, 1'b0, sidt_pkg::STATUS_OK, 4'd0});
      text_expected.push_back('{sidt_pkg::CHAR_NUL, 1'b1, 1'b1, sidt_pkg::STATUS_OK, 4'd1});
      return;
    end

    // digits least significant first
    digit_total = '0;
    while (mag != 0 && digit_total < DIGIT_SLOTS) begin
      digit_slots[digit_total] = 4'(mag % 10);
      digit_total++;
      mag = mag / 10;
    end

    if (neg) begin
      text_expected.push_back('{sidt_pkg::CHAR_MINUS, 1'b1, 1'b0, sidt_pkg::STATUS_OK, 4'd0});
      room--;
    end

    emitted_digits = '0;
    if (int'(digit_total) > room) begin
      // keep the leading digits, one fewer than the room left after the terminator
      for (i = 0; i < room - 1; i++) begin
        text_expected.push_back('{sidt_pkg::CHAR_ZERO + 8'(digit_slots[digit_total - 1 - i]),
                                  1'b1, 1'b0, sidt_pkg::STATUS_OK, 4'd0});
        emitted_digits++;
      end
      text_expected.push_back('{sidt_pkg::CHAR_NUL, 1'b1, 1'b1, sidt_pkg::STATUS_TRUNC, 4'd0});
      truncated++;
      return;
    end

    for (i = 0; i < int'(digit_total); i++) begin
      text_expected.push_back('{sidt_pkg::CHAR_ZERO + 8'(digit_slots[digit_total - 1 - i]),
                                1'b1, 1'b0, sidt_pkg::STATUS_OK, 4'd0});
      emitted_digits++;
    end
    text_expected.push_back('{sidt_pkg::CHAR_NUL, 1'b1, 1'b1, sidt_pkg::STATUS_OK, digit_total});
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the next value after its idle gap and holds it until taken
  // ---------------------------------------------------------------------------
  int unsigned gap_count = 0;
  logic        holding;
  logic        launch;

  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      value     <= '0;
      gap_count = 0;
    end else begin
      launch  = 1'b0;
      holding = start && busy;
      // a word is taken on this edge: predict its text right away
      if (start && !busy) begin
        predict_text(value);
        words_taken <= words_taken + 1;
      end
      if (!holding && values_pending.size() != 0) begin
        if (gap_count < values_pending[0].gap) begin
          gap_count++;
        end else if (!values_pending[0].drain ||
                     (text_expected.size() == 0 && !strobe)) begin
          // drain wait: strobe still high means the last word is landing this edge
          launch    = 1'b1;
          value     <= values_pending[0].val;
          gap_count = 0;
          void'(values_pending.pop_front());
        end
      end
      // one assignment per edge, so a back-to-back value keeps start high
      start <= holding || launch;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed word against the oldest expectation
  // ---------------------------------------------------------------------------
  text_word_t want;

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (text_expected.size() == 0) begin
        $error("unexpected word: char_code %h char_valid %b last %b status %0d text_length %0d",
               char_code, char_valid, last, status, text_length);
        fail_count++;
      end else begin
        want = text_expected.pop_front();
        words_checked++;
        if (char_code !== want.code) begin
          $error("char_code: expected %h, got %h", want.code, char_code);
          fail_count++;
        end
        if (char_valid !== want.valid) begin
          $error("char_valid: expected %b, got %b", want.valid, char_valid);
          fail_count++;
        end
        if (last !== want.fin) begin
          $error("last: expected %b, got %b", want.fin, last);
          fail_count++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, status);
          fail_count++;
        end
        if (text_length !== want.length) begin
          $error("text_length: expected %0d, got %0d", want.length, text_length);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no word moves for too long
  // ---------------------------------------------------------------------------
  int stall_cycles = 0;

  initial begin
    do begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe) stall_cycles = 0;
      else stall_cycles++;
    end while (stall_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("signed_int_to_decimal_text_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequencer helpers
  // ---------------------------------------------------------------------------

  // one apb transfer: setup cycle, access cycle, done when pready is seen
  task automatic reg_access(input bit wr, input logic [sidt_pkg::APB_DATA_W-1:0] wdata,
                            output logic [sidt_pkg::APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BUFFER_SIZE;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_room_reg(input logic [sidt_pkg::CFG_W-1:0] want_room);
    logic [sidt_pkg::APB_DATA_W-1:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd[sidt_pkg::CFG_W-1:0] !== want_room) begin
      $error("buffer_size readback: expected %0d, got %0d", want_room,
             rd[sidt_pkg::CFG_W-1:0]);
      fail_count++;
    end
  endtask

  // upper data bits are junk on purpose, only the low byte is the register
  task automatic set_room(input logic [sidt_pkg::CFG_W-1:0] room);
    logic [sidt_pkg::APB_DATA_W-1:0] rd;
    reg_access(1'b1, {24'($urandom), room}, rd);
    room_setting = room;
    settings_used++;
    check_room_reg(room);
  endtask

  task automatic queue_value(input logic [sidt_pkg::VALUE_W-1:0] v, input int unsigned gap,
                             input bit drain);
    values_pending.push_back('{v, gap, drain});
    words_queued++;
  endtask

  // random value: mostly digit-count boundaries and small numbers, some full range
  function automatic logic [sidt_pkg::VALUE_W-1:0] draw_value();
    logic [sidt_pkg::VALUE_W-1:0] v;
    logic [sidt_pkg::VALUE_W-1:0] p;
    int                           k;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        p = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p - 32'($urandom_range(0, 1));
      end
      3: v = $urandom_range(0, 9);
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (v != 32'h8000_0000 && $urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  // wait until every value is taken, every word has come and the block is idle
  task automatic settle();
    do @(posedge clk);
    while (words_taken != words_queued || start || strobe ||
           text_expected.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequencer: directed corners, then random phases under several buffer sizes
  // ---------------------------------------------------------------------------
  int corner_values[14] = '{0, 1, -1, 9, 10, -10, 99, -100, 2147483647, 32'h8000_0000,
                            1000000000, -999999999, 123456789, -123456789};
  int room_plan[10]     = '{11, 255, 4, 7, 2, 0, 0, 0, 12, 10};

  initial begin
    int          p;
    int          i;
    int          n;
    bit          idle_on;
    int unsigned gap;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_room_reg(sidt_pkg::BUFFER_SIZE_RESET);

    // corners at the reset size; one value in the middle waits for a full drain
    @(negedge clk);
    for (i = 0; i < 14; i++)
      queue_value(corner_values[i], (i % 3 == 0) ? $urandom_range(0, 17) : 0, i == 7);
    settle();

    // room for the terminator only: everything is no-room
    set_room(8'd1);
    @(negedge clk);
    queue_value(32'd0, 0, 0);
    queue_value(32'd5, 0, 0);
    queue_value(-32'sd5, 3, 0);
    settle();

    // one character: zero and single digits fit, longer positive text is cut to nothing, a negative value has no room
    set_room(8'd2);
    @(negedge clk);
    queue_value(32'd0, 0, 0);
    queue_value(32'd7, 0, 0);
    queue_value(32'd42, 5, 0);
    queue_value(-32'sd1, 0, 0);
    settle();

    // two characters: a minus plus one digit, a cut after the sign, or one digit of a cut positive value
    set_room(8'd3);
    @(negedge clk);
    queue_value(-32'sd1, 0, 0);
    queue_value(-32'sd12, 0, 0);
    queue_value(32'd123, 11, 0);
    queue_value(32'h8000_0000, 0, 0);
    settle();

    // random phases, alternating busy streams with gappy ones
    room_plan[6] = $urandom_range(0, 255);
    room_plan[7] = $urandom_range(0, 255);
    for (p = 0; p < 10; p++) begin
      set_room(8'(room_plan[p]));
      idle_on = p[0];
      n = (room_plan[p] < 2) ? 8 : 20;
      @(negedge clk);
      for (i = 0; i < n; i++) begin
        gap = (idle_on && $urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : 0;
        queue_value(draw_value(), gap, idle_on && $urandom_range(0, 15) == 0);
      end
      settle();
    end

    $display("covered %0d values over %0d buffer_size settings, %0d text words checked",
             words_taken, settings_used, words_checked);
    $display("including %0d no-room and %0d truncated conversions", no_room_count, truncated);
    if (fail_count == 0) begin
      $display("signed_int_to_decimal_text_tb: done, clean");
    end else begin
      $display("signed_int_to_decimal_text_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sidt_pkg.sv
rtl/core/sidt_dabble.sv
rtl/core/signed_int_to_decimal_text.sv
rtl/core/sidt_checker.sv
verif/signed_int_to_decimal_text_tb.sv
